@@ sv/command_frame_builder_crc16_core_defines.svh @@
// ----------------------------------------------------------------------------
// Command frame builder assertion macros
// Shared assertion forms for the command frame builder RTL.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_BUILDER_CRC16_CORE_DEFINES_SVH
`define COMMAND_FRAME_BUILDER_CRC16_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CFBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CFBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/cfbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Command frame builder package
// Types, constants and the bytewise CRC-16 update shared by the frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package cfbc_pkg;

	localparam int MAX_PAYLOAD = 232;
	localparam int COUNT_W     = 8;
	localparam logic [15:0] CRC_TAPS = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hC181;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_FIRST = 2'd0,
		OP_DATA  = 2'd1,
		OP_ERR   = 2'd2
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        last;
		logic [7:0]  payload_byte;
		logic [15:0] node_id;
		logic [7:0]  command;
	} q_entry_t;

	typedef struct packed {
		logic push_ready;
		logic head_valid;
	} q_status_t;

	typedef enum logic [6:0] {
		ST_START = 7'b0000001,
		ST_IDLO  = 7'b0000010,
		ST_IDHI  = 7'b0000100,
		ST_CMD   = 7'b0001000,
		ST_DATA  = 7'b0010000,
		ST_CRCLO = 7'b0100000,
		ST_CRCHI = 7'b1000000
	} step_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_TAPS;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ sv/command_frame_builder_crc16_core.sv @@
// Command frame builder with CRC-16. Each input word carries one payload byte;
// the word marked first also carries the node id and command. The block emits
// id low, id high, command, the payload bytes and then the CRC-16 (reflected
// 0xA001, seed 0xC181, low byte first), or a single length_error word when the
// payload exceeds 232 bytes. Input words are taken one per cycle, while there is
// room, into a four-entry operation queue; frame bytes leave the output register
// one per cycle while frame_ready is high. A first word yields 4 output words
// (6 with last), a middle word 1, a last word 3, so the sustained input rate is
// one word per output word it yields, set by the single-byte output port. An
// accepted word is registered in the operation queue, then in the output register.
// ----------------------------------------------------------------------------
// Command frame builder top level
// Front end, operation queue and byte sequencer with output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "command_frame_builder_crc16_core_defines.svh"

module command_frame_builder_crc16_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         item_valid,
	output logic        item_ready,
	input  wire  [7:0]  payload_byte,
	input  wire         first,
	input  wire         last,
	input  wire  [15:0] node_id,
	input  wire  [7:0]  command,
	output logic        frame_valid,
	input  wire         frame_ready,
	output logic [7:0]  frame_byte,
	output logic        frame_end,
	output logic        length_error
);

	cfbc_pkg::q_status_t q_status;
	cfbc_pkg::q_entry_t  push_entry;
	cfbc_pkg::q_entry_t  head;
	logic                push_valid;
	logic                pop;

	cfbc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.payload_byte (payload_byte),
		.first        (first),
		.last         (last),
		.node_id      (node_id),
		.command      (command),
		.q_status     (q_status),
		.push_valid   (push_valid),
		.push_entry   (push_entry)
	);

	cfbc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_status   (q_status)
	);

	cfbc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame_byte   (frame_byte),
		.frame_end    (frame_end),
		.length_error (length_error)
	);

	`CFBC_ASSERT_NOW(a_err_word, clk, arst_n, frame_valid && length_error, frame_end && (frame_byte == 8'h00), "error word not terminal or nonzero")
	`CFBC_ASSERT_NOW(a_pop_nonempty, clk, arst_n, pop, q_status.head_valid, "pop from empty queue")
	`CFBC_ASSERT_NEXT(a_drain, clk, arst_n, q_status.head_valid && (!frame_valid || frame_ready), frame_valid, "queued operation not issued")

endmodule

`default_nettype wire

@@ sv/cfbc_front.sv @@
// ----------------------------------------------------------------------------
// Command frame builder front end
// Accepts input words, tracks the open frame and queues one operation per
// word that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module cfbc_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_ready,
	input  wire  [7:0]           payload_byte,
	input  wire                  first,
	input  wire                  last,
	input  wire  [15:0]          node_id,
	input  wire  [7:0]           command,
	input  cfbc_pkg::q_status_t  q_status,
	output logic                 push_valid,
	output cfbc_pkg::q_entry_t   push_entry
);

	logic [cfbc_pkg::COUNT_W-1:0] count_q;
	logic                         accept;
	logic                         overflow;

	assign item_ready = q_status.push_ready;
	assign accept     = item_valid && item_ready;
	assign overflow   = count_q >= cfbc_pkg::COUNT_W'(cfbc_pkg::MAX_PAYLOAD);
	assign push_valid = accept && (first || (count_q != '0));

	always_comb begin
		push_entry.op           = first ? cfbc_pkg::OP_FIRST :
		                          (overflow ? cfbc_pkg::OP_ERR : cfbc_pkg::OP_DATA);
		push_entry.last         = last;
		push_entry.payload_byte = payload_byte;
		push_entry.node_id      = node_id;
		push_entry.command      = command;
	end

	// drop words with no open frame; close on last or overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (first) begin
				count_q <= last ? '0 : cfbc_pkg::COUNT_W'(1);
			end else if (count_q != '0) begin
				if (overflow || last) begin
					count_q <= '0;
				end else begin
					count_q <= count_q + cfbc_pkg::COUNT_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/cfbc_queue.sv @@
// ----------------------------------------------------------------------------
// Command frame builder operation queue
// Small FIFO between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cfbc_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push_valid,
	input  cfbc_pkg::q_entry_t   push_entry,
	input  wire                  pop,
	output cfbc_pkg::q_entry_t   head,
	output cfbc_pkg::q_status_t  q_status
);

	cfbc_pkg::q_entry_t           ent_q [cfbc_pkg::QUEUE_DEPTH];
	logic [cfbc_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [cfbc_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [cfbc_pkg::QFILL_W-1:0] fill_q;
	logic                         do_push;
	logic                         do_pop;

	assign q_status.push_ready = fill_q != cfbc_pkg::QFILL_W'(cfbc_pkg::QUEUE_DEPTH);
	assign q_status.head_valid = fill_q != '0;
	assign head                = ent_q[rd_ptr_q];
	assign do_push             = push_valid && q_status.push_ready;
	assign do_pop              = pop && q_status.head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + cfbc_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + cfbc_pkg::QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + cfbc_pkg::QFILL_W'(1);
				2'b01:   fill_q <= fill_q - cfbc_pkg::QFILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/cfbc_back.sv @@
// ----------------------------------------------------------------------------
// Command frame builder byte sequencer
// Expands queued operations into frame bytes, runs the CRC-16 and drives
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfbc_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cfbc_pkg::q_entry_t   head,
	input  cfbc_pkg::q_status_t  q_status,
	output logic                 pop,
	output logic                 frame_valid,
	input  wire                  frame_ready,
	output logic [7:0]           frame_byte,
	output logic                 frame_end,
	output logic                 length_error
);

	cfbc_pkg::step_t step_q;
	cfbc_pkg::step_t cur_step;
	cfbc_pkg::step_t nxt_step;
	logic [15:0]     crc_q;
	logic [15:0]     crc_base;
	logic [15:0]     crc_upd;
	logic [15:0]     crc_nxt;
	logic            load;
	logic            fire;
	logic            done;
	logic [7:0]      byte_d;
	logic            end_d;
	logic            err_d;
	logic            valid_q;
	logic [7:0]      byte_q;
	logic            end_q;
	logic            err_q;

	assign load = !valid_q || frame_ready;
	assign fire = q_status.head_valid && load;
	assign pop  = fire && done;

	always_comb begin
		if (step_q != cfbc_pkg::ST_START) begin
			cur_step = step_q;
		end else begin
			case (head.op)
				cfbc_pkg::OP_FIRST: cur_step = cfbc_pkg::ST_IDLO;
				cfbc_pkg::OP_DATA:  cur_step = cfbc_pkg::ST_DATA;
				default:            cur_step = cfbc_pkg::ST_START;
			endcase
		end
	end

	assign crc_base = (cur_step == cfbc_pkg::ST_IDLO) ? cfbc_pkg::CRC_INIT : crc_q;
	assign crc_upd  = cfbc_pkg::crc_byte(crc_base, byte_d);

	always_comb begin
		byte_d   = 8'h00;
		end_d    = 1'b0;
		err_d    = 1'b0;
		nxt_step = cfbc_pkg::ST_START;
		done     = 1'b0;
		case (cur_step)
			cfbc_pkg::ST_IDLO: begin
				byte_d   = head.node_id[7:0];
				nxt_step = cfbc_pkg::ST_IDHI;
			end
			cfbc_pkg::ST_IDHI: begin
				byte_d   = head.node_id[15:8];
				nxt_step = cfbc_pkg::ST_CMD;
			end
			cfbc_pkg::ST_CMD: begin
				byte_d   = head.command;
				nxt_step = cfbc_pkg::ST_DATA;
			end
			cfbc_pkg::ST_DATA: begin
				byte_d   = head.payload_byte;
				nxt_step = head.last ? cfbc_pkg::ST_CRCLO : cfbc_pkg::ST_START;
				done     = !head.last;
			end
			cfbc_pkg::ST_CRCLO: begin
				byte_d   = crc_q[7:0];
				nxt_step = cfbc_pkg::ST_CRCHI;
			end
			cfbc_pkg::ST_CRCHI: begin
				byte_d = crc_q[15:8];
				end_d  = 1'b1;
				done   = 1'b1;
			end
			default: begin
				// length error word
				end_d = 1'b1;
				err_d = 1'b1;
				done  = 1'b1;
			end
		endcase
	end

	always_comb begin
		case (cur_step)
			cfbc_pkg::ST_CRCLO: crc_nxt = crc_q;
			cfbc_pkg::ST_IDLO, cfbc_pkg::ST_IDHI, cfbc_pkg::ST_CMD,
			cfbc_pkg::ST_DATA:  crc_nxt = crc_upd;
			default:            crc_nxt = cfbc_pkg::CRC_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= cfbc_pkg::ST_START;
			crc_q   <= cfbc_pkg::CRC_INIT;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				step_q  <= nxt_step;
				crc_q   <= crc_nxt;
				valid_q <= 1'b1;
			end else if (frame_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= byte_d;
			end_q  <= end_d;
			err_q  <= err_d;
		end
	end

	assign frame_valid  = valid_q;
	assign frame_byte   = byte_q;
	assign frame_end    = end_q;
	assign length_error = err_q;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Command frame builder testbench
// Drives payload words into the CRC-16 frame builder with random gaps on the
// input side and random stalls on the output side. A scoreboard predicts the
// frame bytes (id, command, payload, CRC trailer, length aborts) and checks
// every output word in order. The run covers directed corner frames, random
// short frames with noise, and a frame that fills the length limit and then
// overflows.
// ----------------------------------------------------------------------------
`default_nettype none

package frame_check_pkg;

	localparam logic [15:0] CRC_REFLECTED_POLY = 16'hA001;
	localparam logic [15:0] CRC_SEED           = 16'hC181;
	localparam int          PAYLOAD_LIMIT      = 232;
	localparam int          REPORT_LIMIT       = 10;

	typedef struct packed {
		logic [7:0] fbyte;
		logic       fend;
		logic       ferr;
	} frame_word_t;

	class frame_scoreboard;
		logic [15:0] crc_acc;
		logic [7:0]  byte_count;
		bit          dropping;
		frame_word_t frame_words_due[$];
		int          failures;
		int          words_in;
		int          words_out;
		int          frames_closed;
		int          aborts;
		int          dropped;

		function new();
			crc_acc = CRC_SEED;
			byte_count = 8'd0;
			dropping = 1'b0;
			failures = 0;
			words_in = 0;
			words_out = 0;
			frames_closed = 0;
			aborts = 0;
			dropped = 0;
		endfunction

		function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c ^ {8'h00, b};
			repeat (8) r = r[0] ? ((r >> 1) ^ CRC_REFLECTED_POLY) : (r >> 1);
			return r;
		endfunction

		function void push_word(logic [7:0] b, logic fend, logic ferr);
			frame_word_t w;
			w.fbyte = b;
			w.fend = fend;
			w.ferr = ferr;
			frame_words_due.push_back(w);
		endfunction

		function void push_data(logic [7:0] b);
			crc_acc = crc_update(crc_acc, b);
			push_word(b, 1'b0, 1'b0);
		endfunction

		function void note_word(logic [7:0] pb, logic fst, logic lst, logic [15:0] id,
			logic [7:0] cmd);
			words_in++;
			if (fst) begin
				crc_acc = CRC_SEED;
				dropping = 1'b0;
				byte_count = 8'd0;
				push_data(id[7:0]);
				push_data(id[15:8]);
				push_data(cmd);
			end else begin
				if (dropping || byte_count == 8'd0) begin
					dropped++;
					return;
				end
				if (byte_count >= 8'(PAYLOAD_LIMIT)) begin
					dropping = 1'b1;
					byte_count = 8'd0;
					crc_acc = CRC_SEED;
					aborts++;
					push_word(8'h00, 1'b1, 1'b1);
					return;
				end
			end
			push_data(pb);
			byte_count++;
			if (lst) begin
				push_word(crc_acc[7:0], 1'b0, 1'b0);
				push_word(crc_acc[15:8], 1'b1, 1'b0);
				byte_count = 8'd0;
				crc_acc = CRC_SEED;
				frames_closed++;
			end
		endfunction

		function void check_result(logic [7:0] fbyte, logic fend, logic ferr);
			frame_word_t seen;
			frame_word_t due;
			seen.fbyte = fbyte;
			seen.fend = fend;
			seen.ferr = ferr;
			words_out++;
			if (frame_words_due.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected word: byte %02h end %0b err %0b", fbyte, fend, ferr);
				return;
			end
			due = frame_words_due.pop_front();
			if (seen !== due) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("mismatch: expected byte %02h end %0b err %0b, got byte %02h end %0b err %0b",
						due.fbyte, due.fend, due.ferr, fbyte, fend, ferr);
			end
		endfunction

		function int pending();
			return frame_words_due.size();
		endfunction

		function int error_count();
			return failures + frame_words_due.size();
		endfunction
	endclass

endpackage

module tb_top;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_WORDS   = 60;
	localparam int CALM_FROM      = 45;
	localparam int PRESSURE_AT    = 20;
	localparam int DRAIN_CYCLES   = 20;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [7:0]  payload_byte;
	logic        first;
	logic        last;
	logic [15:0] node_id;
	logic [7:0]  command;
	logic        frame_valid;
	logic        frame_ready;
	logic [7:0]  frame_byte;
	logic        frame_end;
	logic        length_error;

	frame_check_pkg::frame_scoreboard sb;
	bit calm;
	int ready_left;
	int idle_cycles;
	int random_words;

	command_frame_builder_crc16_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.payload_byte(payload_byte),
		.first(first),
		.last(last),
		.node_id(node_id),
		.command(command),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.frame_byte(frame_byte),
		.frame_end(frame_end),
		.length_error(length_error)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (calm) begin
			frame_ready <= 1'b1;
		end else if (ready_left > 0) begin
			ready_left--;
		end else if (frame_ready && $urandom_range(0, 1) == 1) begin
			frame_ready <= 1'b0;
			ready_left = $urandom_range(0, 8);
		end else begin
			frame_ready <= 1'b1;
			ready_left = $urandom_range(0, 19);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				sb.note_word(payload_byte, first, last, node_id, command);
			if (frame_valid && frame_ready)
				sb.check_result(frame_byte, frame_end, length_error);
			if ((item_valid && item_ready) || (frame_valid && frame_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [7:0] pb, input logic fst, input logic lst,
		input logic [15:0] id, input logic [7:0] cmd);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		item_valid <= 1'b1;
		payload_byte <= pb;
		first <= fst;
		last <= lst;
		node_id <= id;
		command <= cmd;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic send_frame(input int len, input bit closed);
		logic [15:0] id;
		logic [7:0]  cmd;
		id = 16'($urandom_range(0, 65535));
		cmd = 8'($urandom_range(0, 255));
		for (int i = 0; i < len; i++) begin
			if (i == 0)
				send_word(8'($urandom_range(0, 255)), 1'b1, closed && len == 1, id, cmd);
			else
				send_word(8'($urandom_range(0, 255)), 1'b0, closed && i == len - 1,
					16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int kind;
		int len;
		clk = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		payload_byte = 8'h00;
		first = 1'b0;
		last = 1'b0;
		node_id = 16'h0000;
		command = 8'h00;
		frame_ready = 1'b0;
		calm = 1'b0;
		ready_left = 0;
		idle_cycles = 0;
		random_words = 0;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// drop: no frame open after reset
		send_word(8'h5A, 1'b0, 1'b0, 16'h1111, 8'h22);
		send_word(8'hA5, 1'b0, 1'b1, 16'h3333, 8'h44);
		send_word(8'h00, 1'b1, 1'b1, 16'h0000, 8'h00);
		send_word(8'hFF, 1'b1, 1'b1, 16'hFFFF, 8'hFF);
		send_word(8'h77, 1'b0, 1'b0, 16'hFFFF, 8'hFF);
		send_word(8'h00, 1'b1, 1'b0, 16'h1234, 8'h5A);
		send_word(8'hFF, 1'b0, 1'b0, 16'hFFFF, 8'hFF);
		send_word(8'h80, 1'b0, 1'b1, 16'h0000, 8'h00);
		send_word(8'h01, 1'b1, 1'b0, 16'h8001, 8'h80);
		send_word(8'h7F, 1'b0, 1'b0, 16'h7FFE, 8'h7F);
		// restart in the middle of an open frame
		send_word(8'hC3, 1'b1, 1'b0, 16'hAAAA, 8'h55);
		send_word(8'h3C, 1'b0, 1'b1, 16'h5555, 8'hAA);
		send_word(8'hAA, 1'b1, 1'b1, 16'h00FF, 8'h01);
		send_word(8'h55, 1'b1, 1'b1, 16'hFF00, 8'hFE);

		while (random_words < RANDOM_WORDS || sb.aborts == 0 || !calm) begin
			if (random_words >= PRESSURE_AT && sb.aborts == 0) begin
				item_valid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0) @(posedge clk);
				send_frame(frame_check_pkg::PAYLOAD_LIMIT, 1'b0);
				send_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
					16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
				send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 16'h0000, 8'h00);
				send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 16'hFFFF, 8'hFF);
			end
			if (random_words >= CALM_FROM)
				calm = 1'b1;
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				send_frame(len, 1'b1);
				random_words += len;
			end else if (kind == 7) begin
				len = $urandom_range(1, 6);
				send_frame(len, 1'b0);
				random_words += len;
			end else if (kind == 8) begin
				repeat ($urandom_range(1, 3))
					send_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
						16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
			end else begin
				len = $urandom_range(1, 4);
				repeat (len)
					send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
						1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
						8'($urandom_range(0, 255)));
				random_words += len;
			end
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d input words, %0d output words, %0d frames closed",
			sb.words_in, sb.words_out, sb.frames_closed);
		$display("summary: %0d length aborts, %0d words dropped, %0d failures",
			sb.aborts, sb.dropped, sb.error_count());
		if (sb.error_count() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

`default_nettype wire
